[rtl/tsmgd_pkg.sv]
`timescale 1ns / 1ps

package tsmgd_pkg;

  localparam int CFG_IDX_WIDTH  = 1;
  localparam int CFG_DATA_WIDTH = 16;
  localparam int MODE_WIDTH     = 3;
  localparam int VALUE_WIDTH    = 16;

  typedef logic [MODE_WIDTH-1:0] mode_t;

  localparam mode_t MODE_X_MOTION = 3'd0;
  localparam mode_t MODE_Y_MOTION = 3'd1;
  localparam mode_t MODE_OTHER    = 3'd2;
  localparam mode_t MODE_ARM      = 3'd3;
  localparam mode_t MODE_DISARM   = 3'd4;
  localparam mode_t MODE_TICK     = 3'd5;

  typedef logic [CFG_IDX_WIDTH-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_IDX_THRESHOLD = 1'd0;
  localparam cfg_idx_t CFG_IDX_TIMEOUT   = 1'd1;

  localparam logic [CFG_DATA_WIDTH-1:0] THRESHOLD_RESET = 16'd50;
  localparam logic [CFG_DATA_WIDTH-1:0] TIMEOUT_RESET   = 16'd300;

  typedef logic [1:0] dir_t;

  localparam dir_t DIR_RIGHT = 2'd0;
  localparam dir_t DIR_LEFT  = 2'd1;
  localparam dir_t DIR_DOWN  = 2'd2;
  localparam dir_t DIR_UP    = 2'd3;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_ARMED = 3'b010,
    PH_WAIT  = 3'b100
  } phase_t;

endpackage

[rtl/two_stroke_motion_gesture_detector_unit.sv]
`timescale 1ns / 1ps

// Two-stroke motion gesture detector. Every accepted request gives exactly one
// result, in order. A request is held in an input register, then processed in
// a single pass that updates the accumulators, stroke timer and phase and
// writes the result register, so a request passes the input register and then
// the result register, and one request can be taken every cycle while the
// result side is not stalled.
// A full result register that is stalled holds one request in the input
// register before in_stall rises. Configuration writes take effect on the
// next request processed.
module two_stroke_motion_gesture_detector_unit
  import tsmgd_pkg::*;
#(
  parameter int SUM_WIDTH        = 32,
  parameter int TICK_COUNT_WIDTH = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,

  input  logic                      cfg_wr_en,
  input  logic [CFG_IDX_WIDTH-1:0]  cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0] cfg_wdata,

  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [MODE_WIDTH-1:0]     in_mode,
  input  logic signed [VALUE_WIDTH-1:0] in_motion_value,
  input  logic                      in_batch_end,

  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_suppressed,
  output logic                      out_gesture_fired,
  output logic [1:0]                out_first_direction,
  output logic [1:0]                out_second_direction
);

  localparam int SW  = SUM_WIDTH;
  localparam int TW  = TICK_COUNT_WIDTH;
  localparam int LW  = (TW > CFG_DATA_WIDTH) ? TW : CFG_DATA_WIDTH;

  localparam logic [SW:0] SUM_HI = {2'b00, {(SW-1){1'b1}}};
  localparam logic [SW:0] SUM_LO = {2'b11, {(SW-1){1'b0}}};
  localparam logic [LW-1:0] CNT_MAX = LW'({TW{1'b1}});

  // configuration
  logic [CFG_DATA_WIDTH-1:0] threshold_r;
  logic [CFG_DATA_WIDTH-1:0] timeout_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RESET;
      timeout_r   <= TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_IDX_THRESHOLD: threshold_r <= cfg_wdata;
        CFG_IDX_TIMEOUT:   timeout_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register and result register handshake
  logic                          s1_valid_r;
  mode_t                         s1_mode_r;
  logic signed [VALUE_WIDTH-1:0] s1_value_r;
  logic                          s1_last_r;

  logic out_valid_r;
  logic out_supp_r;
  logic out_fired_r;
  dir_t out_d1_r;
  dir_t out_d2_r;

  logic out_take;
  logic s1_move;
  logic s1_take;

  assign out_take = !out_valid_r || !out_stall;
  assign s1_move  = s1_valid_r && out_take;
  assign s1_take  = !s1_valid_r || s1_move;
  assign in_stall = !s1_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_take) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take && in_valid) begin
      s1_mode_r  <= in_mode;
      s1_value_r <= in_motion_value;
      s1_last_r  <= in_batch_end;
    end
  end

  // detector state
  phase_t               phase_r,   phase_nxt;
  dir_t                 first_r,   first_nxt;
  logic signed [SW-1:0] sum_x_r,   sum_x_nxt;
  logic signed [SW-1:0] sum_y_r,   sum_y_nxt;
  logic [TW-1:0]        wait_cnt_r, wait_cnt_nxt;
  logic                 wait_run_r, wait_run_nxt;

  logic supp_nxt;
  logic fired_nxt;
  dir_t d1_nxt;
  dir_t d2_nxt;

  logic [SW:0]    acc_ext;
  logic [SW:0]    add_sum;
  logic [SW-1:0]  acc_sat;
  logic [SW-1:0]  new_x;
  logic [SW-1:0]  new_y;
  logic [SW-1:0]  mag_x;
  logic [SW-1:0]  mag_y;
  logic [SW-1:0]  mag_max;
  logic           is_stroke;
  dir_t           dir;
  logic [LW-1:0]  timeout_ext;
  logic [TW-1:0]  load_val;

  always_comb begin
    // saturating add on whichever axis this motion event moves
    acc_ext = (s1_mode_r == MODE_Y_MOTION) ? {sum_y_r[SW-1], sum_y_r}
                                           : {sum_x_r[SW-1], sum_x_r};
    add_sum = acc_ext + {{(SW+1-VALUE_WIDTH){s1_value_r[VALUE_WIDTH-1]}}, s1_value_r};
    if (add_sum[SW] != add_sum[SW-1]) begin
      acc_sat = add_sum[SW] ? SUM_LO[SW-1:0] : SUM_HI[SW-1:0];
    end else begin
      acc_sat = add_sum[SW-1:0];
    end
    new_x = (s1_mode_r == MODE_X_MOTION) ? acc_sat : sum_x_r;
    new_y = (s1_mode_r == MODE_Y_MOTION) ? acc_sat : sum_y_r;

    // the most negative sum maps onto its own pattern, read as unsigned
    mag_x   = new_x[SW-1] ? (~new_x + SW'(1)) : new_x;
    mag_y   = new_y[SW-1] ? (~new_y + SW'(1)) : new_y;
    mag_max = (mag_x > mag_y) ? mag_x : mag_y;
    is_stroke = (mag_max >= SW'(threshold_r));

    // horizontal wins ties, zero sums give left
    if (mag_x >= mag_y) begin
      dir = (!new_x[SW-1] && (new_x != '0)) ? DIR_RIGHT : DIR_LEFT;
    end else begin
      dir = (!new_y[SW-1] && (new_y != '0)) ? DIR_DOWN : DIR_UP;
    end

    timeout_ext = LW'(timeout_r);
    load_val    = (timeout_ext > CNT_MAX) ? TW'(CNT_MAX) : TW'(timeout_ext);

    phase_nxt    = phase_r;
    first_nxt    = first_r;
    sum_x_nxt    = sum_x_r;
    sum_y_nxt    = sum_y_r;
    wait_cnt_nxt = wait_cnt_r;
    wait_run_nxt = wait_run_r;
    supp_nxt     = 1'b0;
    fired_nxt    = 1'b0;
    d1_nxt       = DIR_RIGHT;
    d2_nxt       = DIR_RIGHT;

    priority if (s1_mode_r == MODE_ARM || s1_mode_r == MODE_DISARM) begin
      phase_nxt    = (s1_mode_r == MODE_ARM) ? PH_ARMED : PH_IDLE;
      sum_x_nxt    = '0;
      sum_y_nxt    = '0;
      wait_cnt_nxt = '0;
      wait_run_nxt = 1'b0;
    end else if (s1_mode_r == MODE_TICK) begin
      if (wait_run_r) begin
        if (wait_cnt_r == TW'(0) || wait_cnt_r == TW'(1)) begin
          wait_cnt_nxt = '0;
          wait_run_nxt = 1'b0;
          if (phase_r == PH_WAIT) begin
            sum_x_nxt = '0;
            sum_y_nxt = '0;
          end
        end else begin
          wait_cnt_nxt = wait_cnt_r - TW'(1);
        end
      end
    end else if ((s1_mode_r == MODE_X_MOTION || s1_mode_r == MODE_Y_MOTION) &&
                 phase_r != PH_IDLE) begin
      supp_nxt  = 1'b1;
      sum_x_nxt = new_x;
      sum_y_nxt = new_y;
      if (s1_last_r && is_stroke) begin
        sum_x_nxt = '0;
        sum_y_nxt = '0;
        if (phase_r != PH_WAIT) begin
          first_nxt    = dir;
          phase_nxt    = PH_WAIT;
          wait_cnt_nxt = load_val;
          wait_run_nxt = 1'b1;
        end else if (dir != first_r) begin
          wait_cnt_nxt = '0;
          wait_run_nxt = 1'b0;
          fired_nxt    = 1'b1;
          d1_nxt       = first_r;
          d2_nxt       = dir;
          phase_nxt    = PH_ARMED;
        end else begin
          wait_cnt_nxt = load_val;
          wait_run_nxt = 1'b1;
        end
      end
    end else begin
      // other events, unused modes and motion while disarmed pass through
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      first_r    <= DIR_RIGHT;
      sum_x_r    <= '0;
      sum_y_r    <= '0;
      wait_cnt_r <= '0;
      wait_run_r <= 1'b0;
    end else if (s1_move) begin
      phase_r    <= phase_nxt;
      first_r    <= first_nxt;
      sum_x_r    <= sum_x_nxt;
      sum_y_r    <= sum_y_nxt;
      wait_cnt_r <= wait_cnt_nxt;
      wait_run_r <= wait_run_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_take) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_supp_r  <= supp_nxt;
      out_fired_r <= fired_nxt;
      out_d1_r    <= d1_nxt;
      out_d2_r    <= d2_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_suppressed       = out_supp_r;
  assign out_gesture_fired    = out_fired_r;
  assign out_first_direction  = out_d1_r;
  assign out_second_direction = out_d2_r;

  // a fired gesture always pairs two different strokes
  a_fired_dirs_differ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_fired_r |-> out_d1_r != out_d2_r)
    else $error("gesture fired with equal directions");

  a_nofire_dirs_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_fired_r |-> out_d1_r == DIR_RIGHT && out_d2_r == DIR_RIGHT)
    else $error("directions set without a gesture");

  // the stroke timer only runs while waiting for the second stroke
  a_timer_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    wait_run_r |-> phase_r == PH_WAIT)
    else $error("timer running outside the wait phase");

  a_fire_returns_armed: assert property (@(posedge clk) disable iff (!rst_n)
    s1_move && fired_nxt |=> phase_r == PH_ARMED && !wait_run_r)
    else $error("gesture did not return to armed");

endmodule
